>>> rtl/bsuh_pkg.sv
// ----------------------------------------------------------------------------
// bsuh_pkg
// Shared types, constants and slot arithmetic for the bit-sliced set undo
// history.
// ----------------------------------------------------------------------------
package bsuh_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int MAX_SLOTS    = 32;

   localparam int ELEM_AW = $clog2(MAX_ELEMENTS);   // element index width
   localparam int CNT_W   = ELEM_AW + 1;            // holds the count itself
   localparam int SLOT_W  = 5;                      // slot index width
   localparam int SLOTS_W = 6;                      // slot count width
   localparam int PADDR_W = 3;

   localparam logic [ELEM_AW-1:0] ELEM_LAST = ELEM_AW'(MAX_ELEMENTS - 1);

   // Register indexes on the configuration port.
   localparam logic REG_SLOTS = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   typedef enum logic [2:0] {
      OP_SAVE_BEGIN = 3'd0,
      OP_SAVE_MEMBER = 3'd1,
      OP_SAVE_END   = 3'd2,
      OP_UNDO       = 3'd3,
      OP_REDO       = 3'd4,
      OP_READ       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_NO_UNDO = 2'd1,
      STAT_NO_REDO = 2'd2,
      STAT_DROPPED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MEMBER,
      ST_READ,
      ST_SWEEP
   } state_type;

   // Effective configuration, already saturated into legal ranges.
   typedef struct packed {
      logic [SLOTS_W-1:0] slots;
      logic [CNT_W-1:0]   count;
   } cfg_type;

   typedef struct packed {
      logic             member;
      logic             can_undo;
      logic             can_redo;
      status_type       status;
      logic [SLOT_W-1:0] current_slot;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] slot_fwd(input logic [SLOT_W-1:0]  s,
                                                  input logic [SLOTS_W-1:0] n);
      logic [SLOT_W-1:0] r;
      if ({1'b0, s} >= n - SLOTS_W'(1)) r = '0;
      else r = s + SLOT_W'(1);
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0]  s,
                                                   input logic [SLOTS_W-1:0] n);
      logic [SLOTS_W-1:0] w;
      logic [SLOT_W-1:0]  r;
      w = n - SLOTS_W'(1);
      if (s == '0) r = w[SLOT_W-1:0];
      else r = s - SLOT_W'(1);
      return r;
   endfunction

endpackage

>>> rtl/bsuh_ram.sv
// ----------------------------------------------------------------------------
// bsuh_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bsuh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bsuh_csr.sv
// ----------------------------------------------------------------------------
// bsuh_csr
// Configuration registers on the APB-style port, with saturation of the
// stored values into their effective ranges.
// ----------------------------------------------------------------------------
module bsuh_csr
   import bsuh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [SLOTS_W-1:0] slots_ff, slots_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel & penable & pwrite;

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      if (wr_hit) begin
         case (paddr[2])
            REG_SLOTS: slots_in = pwdata[SLOTS_W-1:0];
            REG_COUNT: count_in = pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_W'(MAX_SLOTS);
         count_ff <= CNT_W'(MAX_ELEMENTS);
      end else begin
         slots_ff <= slots_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SLOTS: prdata = {{(32-SLOTS_W){1'b0}}, slots_ff};
         REG_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_ff};
         default:   prdata = '0;
      endcase
   end

   // Out-of-range settings saturate into the legal ranges.
   always_comb begin
      if (slots_ff < SLOTS_W'(2)) cfg.slots = SLOTS_W'(2);
      else if (slots_ff > SLOTS_W'(MAX_SLOTS)) cfg.slots = SLOTS_W'(MAX_SLOTS);
      else cfg.slots = slots_ff;

      if (count_ff == '0) cfg.count = CNT_W'(1);
      else if (count_ff > CNT_W'(MAX_ELEMENTS)) cfg.count = CNT_W'(MAX_ELEMENTS);
      else cfg.count = count_ff;
   end

endmodule

>>> rtl/bsuh_engine.sv
// ----------------------------------------------------------------------------
// bsuh_engine
// Sequencer for the flag store: clearing pass, read-modify-write of single
// words, and column sweeps for save begin and save end.
// ----------------------------------------------------------------------------
module bsuh_engine
   import bsuh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_operation,
   input  logic [ELEM_AW-1:0]   req_element,
   input  logic                 out_free,
   output logic                 res_valid,
   output rsp_type              res,
   output logic                 ram_wr_en,
   output logic [ELEM_AW-1:0]   ram_wr_addr,
   output logic [MAX_SLOTS-1:0] ram_wr_data,
   output logic                 ram_rd_en,
   output logic [ELEM_AW-1:0]   ram_rd_addr,
   input  logic [MAX_SLOTS-1:0] ram_rd_data
);

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  undo_ff, undo_in;
   logic [SLOT_W-1:0]  redo_ff, redo_in;
   op_type             op_ff, op_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [ELEM_AW-1:0] last_addr_ff, last_addr_in;
   logic [ELEM_AW-1:0] elem_ff, elem_in;
   logic [ELEM_AW-1:0] clr_idx_ff, clr_idx_in;
   logic               diff_ff, diff_in;

   logic [MAX_SLOTS-1:0] cur_mask;
   logic [SLOT_W-1:0]    prev_slot;
   logic                 elem_ok;
   logic                 diff_now;
   logic                 member;
   status_type           status;
   op_type               req_op;

   assign cur_mask  = MAX_SLOTS'(1) << slot_ff;
   assign prev_slot = slot_back(slot_ff, cfg.slots);
   assign elem_ok   = {1'b0, req_element} < cfg.count;
   assign req_op    = op_type'(req_operation);
   assign diff_now  = diff_ff | (ram_rd_data[slot_ff] != ram_rd_data[prev_slot]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         slot_ff    <= '0;
         undo_ff    <= '0;
         redo_ff    <= '0;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         slot_ff    <= slot_in;
         undo_ff    <= undo_in;
         redo_ff    <= redo_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rd_idx_ff    <= rd_idx_in;
      last_addr_ff <= last_addr_in;
      elem_ff      <= elem_in;
      diff_ff      <= diff_in;
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      undo_in      = undo_ff;
      redo_in      = redo_ff;
      op_in        = op_ff;
      rd_idx_in    = rd_idx_ff;
      last_addr_in = last_addr_ff;
      elem_in      = elem_ff;
      clr_idx_in   = clr_idx_ff;
      diff_in      = diff_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      member       = 1'b0;
      status       = STAT_DONE;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = last_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_idx_ff[ELEM_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
            ram_wr_data = '0;
            clr_idx_in  = clr_idx_ff + ELEM_AW'(1);
            if (clr_idx_ff == ELEM_LAST) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               case (req_op)
                  OP_SAVE_BEGIN, OP_SAVE_END: begin
                     if (req_op == OP_SAVE_BEGIN) begin
                        slot_in = slot_fwd(slot_ff, cfg.slots);
                     end
                     op_in        = req_op;
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = '0;
                     last_addr_in = '0;
                     rd_idx_in    = CNT_W'(1);
                     diff_in      = 1'b0;
                     state_in     = ST_SWEEP;
                  end
                  OP_SAVE_MEMBER: begin
                     if (elem_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_element;
                        elem_in     = req_element;
                        state_in    = ST_MEMBER;
                     end else begin
                        res_valid = 1'b1;
                     end
                  end
                  OP_UNDO: begin
                     res_valid = 1'b1;
                     if (undo_ff == '0) begin
                        status = STAT_NO_UNDO;
                     end else begin
                        slot_in = prev_slot;
                        undo_in = undo_ff - SLOT_W'(1);
                        if (redo_ff != '1) redo_in = redo_ff + SLOT_W'(1);
                     end
                  end
                  OP_REDO: begin
                     res_valid = 1'b1;
                     if (redo_ff == '0) begin
                        status = STAT_NO_REDO;
                     end else begin
                        slot_in = slot_fwd(slot_ff, cfg.slots);
                        redo_in = redo_ff - SLOT_W'(1);
                        if (undo_ff != '1) undo_in = undo_ff + SLOT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (elem_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_element;
                        state_in    = ST_READ;
                     end else begin
                        res_valid = 1'b1;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end

         ST_MEMBER: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = elem_ff;
            ram_wr_data = ram_rd_data | cur_mask;
            res_valid   = 1'b1;
            state_in    = ST_IDLE;
         end

         ST_READ: begin
            member    = ram_rd_data[slot_ff];
            res_valid = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_SWEEP: begin
            // Write-back trails the read by one word, so the two never collide.
            if (op_ff == OP_SAVE_BEGIN) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~cur_mask;
            end
            diff_in = diff_now;
            if (rd_idx_ff < cfg.count) begin
               ram_rd_en    = 1'b1;
               last_addr_in = rd_idx_ff[ELEM_AW-1:0];
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end else begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               if (op_ff == OP_SAVE_END) begin
                  if (!diff_now) begin
                     slot_in = prev_slot;
                     status  = STAT_DROPPED;
                  end else begin
                     if ({1'b0, undo_ff} < cfg.slots - SLOTS_W'(1)) begin
                        undo_in = undo_ff + SLOT_W'(1);
                     end
                     redo_in = '0;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res.member       = member;
      res.can_undo     = (undo_in != '0);
      res.can_redo     = (redo_in != '0);
      res.status       = status;
      res.current_slot = slot_in;
   end

endmodule

>>> rtl/bitsliced_set_undo_history.sv
// ----------------------------------------------------------------------------
// bitsliced_set_undo_history
// Circular history of set snapshots kept as one bit column per slot in a
// 1024-word by 32-bit flag store, with save, undo, redo and membership read.
// ----------------------------------------------------------------------------
// Responses: undo, redo, unused operations and member or read of an untracked
// element are answered on acceptance; member and read of a tracked element
// first read the store word and answer from the member or read state. Save
// begin and save end sweep the store one word per cycle over element_count words.
// One transaction is in flight: a new one is taken only after the last answered.
// Reset: a clearing pass writes all 1024 words, accepting nothing.
// ----------------------------------------------------------------------------
module bitsliced_set_undo_history
   import bsuh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   // Configuration port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,

   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [ELEM_AW-1:0] req_element,

   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_member,
   output logic               rsp_can_undo,
   output logic               rsp_can_redo,
   output logic [1:0]         rsp_status,
   output logic [SLOT_W-1:0]  rsp_current_slot
);

   cfg_type              cfg;
   rsp_type              res;
   logic                 res_valid;
   logic                 out_free;

   logic                 ram_wr_en;
   logic [ELEM_AW-1:0]   ram_wr_addr;
   logic [MAX_SLOTS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ELEM_AW-1:0]   ram_rd_addr;
   logic [MAX_SLOTS-1:0] ram_rd_data;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // Configuration registers. Writes are only expected while no transaction
   // is in flight, so the engine samples the effective values directly.
   bsuh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Flag store: word e holds one bit per snapshot slot for element e.
   bsuh_ram #(
      .WIDTH (MAX_SLOTS),
      .DEPTH (MAX_ELEMENTS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The engine takes a new transaction only when the response register
   // will be empty after this edge. Because only one transaction is in
   // flight, the register is then guaranteed free when the result arrives.
   assign out_free = !rsp_valid_ff || rsp_ready;

   bsuh_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_element   (req_element),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   // Response register: holds a finished result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_member       = rsp_ff.member;
   assign rsp_can_undo     = rsp_ff.can_undo;
   assign rsp_can_redo     = rsp_ff.can_redo;
   assign rsp_status       = rsp_ff.status;
   assign rsp_current_slot = rsp_ff.current_slot;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit-sliced set undo history. A request driver
// and a response monitor run as clocked processes; a shadow copy of the flag
// store, slot pointer and undo/redo depths predicts every response, which is
// compared field by field in order. The run steps through several slot and
// element count settings, including out-of-range ones, with random idling on
// both channels and a long response back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import bsuh_pkg::*;

   // Operation codes the block does not define; they must leave state alone.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // Cycles the response side holds off when a long stall is requested.
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [2:0]         op;
      logic [ELEM_AW-1:0] elem;
   } request_type;

   // ------------------------------------------------------------------------
   // Block ports. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic               clock;
   logic               reset         = 1'b1;
   logic               psel          = 1'b0;
   logic               penable       = 1'b0;
   logic               pwrite        = 1'b0;
   logic [PADDR_W-1:0] paddr         = '0;
   logic [31:0]        pwdata        = '0;
   logic [31:0]        prdata;
   logic               pready;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [2:0]         req_operation = '0;
   logic [ELEM_AW-1:0] req_element   = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic               rsp_member;
   logic               rsp_can_undo;
   logic               rsp_can_redo;
   logic [1:0]         rsp_status;
   logic [SLOT_W-1:0]  rsp_current_slot;

   bitsliced_set_undo_history i_dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_member       (rsp_member),
      .rsp_can_undo     (rsp_can_undo),
      .rsp_can_redo     (rsp_can_redo),
      .rsp_status       (rsp_status),
      .rsp_current_slot (rsp_current_slot)
   );

   // ------------------------------------------------------------------------
   // Shadow of the block: flag store, slot pointer, depths and registers.
   // ------------------------------------------------------------------------
   logic [31:0]        flag_copy [MAX_ELEMENTS];
   logic [SLOT_W-1:0]  cur_slot   = '0;
   logic [4:0]         undo_depth = '0;
   logic [4:0]         redo_depth = '0;
   logic [SLOTS_W-1:0] slots_reg  = SLOTS_W'(32);
   logic [CNT_W-1:0]   count_reg  = CNT_W'(1024);

   // Bench bookkeeping.
   request_type        pending_q [$];     // transactions not yet offered
   rsp_type            outcome_q [$];     // predicted responses, oldest first
   logic [ELEM_AW-1:0] last_members [$];  // members of the most recent save
   int                 issued_count   = 0;
   int                 accepted_count = 0;
   int                 mismatch_count = 0;
   int                 gap_left       = 0;
   int                 stall_left     = 0;
   int                 hold_left      = 0;
   int                 hold_requests  = 0;
   int                 holds_started  = 0;
   bit                 quiet_mode     = 1'b0;
   rsp_type            want;
   request_type        launch;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The ceiling assumes every transaction is a full 1024-word sweep with the
   // longest gaps on both sides, plus the clearing pass, and then some.
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // Effective slot count: the register saturates into 2..MAX_SLOTS.
   function automatic int live_slots();
      int n;
      n = slots_reg;
      if (n < 2) n = 2;
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n;
   endfunction

   // Effective element count: the register saturates into 1..MAX_ELEMENTS.
   function automatic int live_count();
      int c;
      c = count_reg;
      if (c < 1) c = 1;
      if (c > MAX_ELEMENTS) c = MAX_ELEMENTS;
      return c;
   endfunction

   // Any pointer at or past the last used slot wraps to zero, which also
   // covers a pointer left beyond a slot count that has since shrunk.
   function automatic logic [SLOT_W-1:0] step_fwd(input int s, input int n);
      return (s >= n - 1) ? SLOT_W'(0) : SLOT_W'(s + 1);
   endfunction

   function automatic logic [SLOT_W-1:0] step_back(input int s, input int n);
      return (s == 0) ? SLOT_W'(n - 1) : SLOT_W'(s - 1);
   endfunction

   // Applies one accepted transaction to the shadow state and returns the
   // response the block owes for it.
   function automatic rsp_type apply_history_op(input request_type rq);
      rsp_type     r;
      int          n;
      int          c;
      int          i;
      logic [31:0] col;
      logic [31:0] prev_col;
      bit          same;
      n   = live_slots();
      c   = live_count();
      r   = '0;
      col = 32'd1 << cur_slot;
      case (rq.op)
         OP_SAVE_BEGIN: begin
            // Open the next slot and wipe its column for the new snapshot.
            cur_slot = step_fwd(cur_slot, n);
            col = 32'd1 << cur_slot;
            for (i = 0; i < c; i++) flag_copy[i] &= ~col;
         end
         OP_SAVE_MEMBER: begin
            if (rq.elem < c) flag_copy[rq.elem] |= col;
         end
         OP_SAVE_END: begin
            prev_col = 32'd1 << step_back(cur_slot, n);
            same = 1'b1;
            for (i = 0; i < c; i++) begin
               if (((flag_copy[i] & prev_col) != 0) != ((flag_copy[i] & col) != 0)) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               cur_slot = step_back(cur_slot, n);
               r.status = STAT_DROPPED;
            end else begin
               if (undo_depth < n - 1) undo_depth++;
               redo_depth = '0;
            end
         end
         OP_UNDO: begin
            if (undo_depth == 0) begin
               r.status = STAT_NO_UNDO;
            end else begin
               cur_slot = step_back(cur_slot, n);
               undo_depth--;
               if (redo_depth < 31) redo_depth++;
            end
         end
         OP_REDO: begin
            if (redo_depth == 0) begin
               r.status = STAT_NO_REDO;
            end else begin
               cur_slot = step_fwd(cur_slot, n);
               redo_depth--;
               if (undo_depth < 31) undo_depth++;
            end
         end
         OP_READ: begin
            if (rq.elem < c) r.member = (flag_copy[rq.elem] & col) != 0;
         end
         default: begin
         end
      endcase
      r.can_undo     = undo_depth != 0;
      r.can_redo     = redo_depth != 0;
      r.current_slot = cur_slot;
      return r;
   endfunction

   // Prints one line per failure and counts it.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR: %s", msg);
   endtask

   // Idle lengths: mostly none or short, now and then a long one. Quiet
   // phases run both channels back to back.
   function automatic int draw_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. A transaction counts as accepted at the edge where
   // valid and ready were both high before the edge; the prediction is made
   // right there so it is in place before the response can show up.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(apply_history_op(request_type'({req_operation, req_element})));
            accepted_count++;
         end
         if (req_valid && !req_ready) begin
            // Still waiting for the block: hold valid and payload steady.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            launch = pending_q.pop_front();
            req_operation <= launch.op;
            req_element   <= launch.elem;
            req_valid     <= 1'b1;
            gap_left = draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response ready. A long hold, when requested by the stimulus, is counted
   // here while the driver keeps offering, so the block backs up and stops
   // taking requests. Otherwise ready drops for random short or long spells.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: each accepted response against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("response at %0t with nothing outstanding", $time));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_member !== want.member)
               report_mismatch($sformatf("member at %0t: got %0d, expected %0d",
                                         $time, rsp_member, want.member));
            if (rsp_can_undo !== want.can_undo)
               report_mismatch($sformatf("can_undo at %0t: got %0d, expected %0d",
                                         $time, rsp_can_undo, want.can_undo));
            if (rsp_can_redo !== want.can_redo)
               report_mismatch($sformatf("can_redo at %0t: got %0d, expected %0d",
                                         $time, rsp_can_redo, want.can_redo));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status at %0t: got %0d, expected %0d",
                                         $time, rsp_status, want.status));
            if (rsp_current_slot !== want.current_slot)
               report_mismatch($sformatf("current_slot at %0t: got %0d, expected %0d",
                                         $time, rsp_current_slot, want.current_slot));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic push_req(input logic [2:0] op, input logic [ELEM_AW-1:0] e);
      pending_q.push_back('{op: op, elem: e});
      issued_count++;
   endtask

   // Register write: setup cycle, then the access cycle. Bits above the
   // register width carry random junk that the block must drop.
   task automatic write_reg(input logic idx, input int unsigned value);
      int unsigned noisy;
      noisy = ($urandom << ((idx == REG_SLOTS) ? SLOTS_W : CNT_W)) | value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= noisy;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_SLOTS) slots_reg = value[SLOTS_W-1:0];
      else count_reg = value[CNT_W-1:0];
   endtask

   // Waits until every queued transaction has gone in and every response has
   // come back, then lets the block settle before registers are touched.
   task automatic drain();
      while (accepted_count != issued_count || outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Elements mostly come from a small hot set so that reads find members;
   // some span the tracked range and a few the full field, past the count.
   function automatic logic [ELEM_AW-1:0] pick_element();
      int c;
      int r;
      c = live_count();
      r = $urandom_range(0, 9);
      if (r == 0) return ELEM_AW'($urandom_range(0, MAX_ELEMENTS - 1));
      if (r < 3) return ELEM_AW'($urandom_range(0, c - 1));
      return ELEM_AW'($urandom_range(0, (c > 12) ? 11 : c - 1));
   endfunction

   // One phase of random traffic. Most of it is complete save sequences so
   // the history actually fills; a replay of the previous member list gives
   // identical snapshots. A few sequences lose their begin or end, and some
   // spare opcodes and stray member or end requests are mixed in.
   task automatic queue_phase(input int n_items);
      int made;
      int r;
      int len;
      logic [ELEM_AW-1:0] e;
      made = 0;
      while (made < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            if ($urandom_range(0, 19) != 0) begin
               push_req(OP_SAVE_BEGIN, ELEM_AW'($urandom));
               made++;
            end
            if (last_members.size() != 0 && $urandom_range(0, 3) == 0) begin
               foreach (last_members[k]) push_req(OP_SAVE_MEMBER, last_members[k]);
               made += last_members.size();
            end else begin
               len = $urandom_range(0, 6);
               last_members.delete();
               repeat (len) begin
                  e = pick_element();
                  last_members.push_back(e);
                  push_req(OP_SAVE_MEMBER, e);
               end
               made += len;
            end
            if ($urandom_range(0, 19) != 0) begin
               push_req(OP_SAVE_END, ELEM_AW'($urandom));
               made++;
            end
         end else if (r < 60) begin
            repeat ($urandom_range(1, 4)) begin
               push_req(OP_UNDO, ELEM_AW'($urandom));
               made++;
            end
         end else if (r < 72) begin
            repeat ($urandom_range(1, 3)) begin
               push_req(OP_REDO, ELEM_AW'($urandom));
               made++;
            end
         end else if (r < 92) begin
            repeat ($urandom_range(1, 3)) begin
               push_req(OP_READ, pick_element());
               made++;
            end
         end else if (r < 96) begin
            // Spare opcodes are ignored by the block and not counted.
            push_req($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, ELEM_AW'($urandom));
         end else begin
            push_req($urandom_range(0, 1) ? OP_SAVE_MEMBER : OP_SAVE_END, pick_element());
            made++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      int p;
      int slot_plan [10];
      int count_plan [10];
      slot_plan  = '{5, 2, 0, 63, 32, 7, 1, 17, 3, 33};
      count_plan = '{16, 1, 0, 2047, 40, 8, 3, 1024, 64, 30};
      foreach (flag_copy[i]) flag_copy[i] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset configuration of 32 slots, 1024 elements.
      // Empty history first: reads of both end elements, and undo and redo
      // with nothing to move to.
      push_req(OP_READ, '0);
      push_req(OP_READ, ELEM_LAST);
      push_req(OP_UNDO, ELEM_LAST);
      push_req(OP_REDO, '0);
      // A distinct snapshot holding the first, last and a middle element.
      push_req(OP_SAVE_BEGIN, '0);
      push_req(OP_SAVE_MEMBER, '0);
      push_req(OP_SAVE_MEMBER, ELEM_LAST);
      push_req(OP_SAVE_MEMBER, ELEM_AW'(512));
      push_req(OP_SAVE_END, ELEM_LAST);
      push_req(OP_READ, ELEM_LAST);
      push_req(OP_READ, '0);
      push_req(OP_READ, ELEM_AW'(5));
      // The same snapshot again is dropped and the slot moves back.
      push_req(OP_SAVE_BEGIN, ELEM_LAST);
      push_req(OP_SAVE_MEMBER, '0);
      push_req(OP_SAVE_MEMBER, ELEM_LAST);
      push_req(OP_SAVE_MEMBER, ELEM_AW'(512));
      push_req(OP_SAVE_END, '0);
      // Undo back to the empty slot, redo forward, then redo past the end.
      push_req(OP_UNDO, '0);
      push_req(OP_REDO, '0);
      push_req(OP_REDO, ELEM_LAST);
      // Spare opcodes change nothing.
      push_req(OP_SPARE_A, ELEM_LAST);
      push_req(OP_SPARE_B, '0);
      // Member and end with no save open work on the current column.
      push_req(OP_SAVE_MEMBER, ELEM_AW'(3));
      push_req(OP_SAVE_END, '0);
      push_req(OP_READ, ELEM_AW'(3));
      drain();

      // Random phases, each under its own configuration. Some settings are
      // out of range on purpose and must saturate.
      for (p = 0; p < 10; p++) begin
         write_reg(REG_SLOTS, slot_plan[p]);
         write_reg(REG_COUNT, count_plan[p]);
         quiet_mode = (p == 3 || p == 7);
         queue_phase(72);
         // Back-pressure while requests are still queued up.
         if (p == 1 || p == 6) hold_requests++;
         drain();
      end

      repeat (20) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", outcome_q.size()));
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> bitsliced_set_undo_history.f
rtl/bsuh_pkg.sv
rtl/bsuh_ram.sv
rtl/bsuh_csr.sv
rtl/bsuh_engine.sv
rtl/bitsliced_set_undo_history.sv
tb/tb_top.sv
